FILE: rtl/pctd_pkg.sv
package pctd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [2:0] {
    PH_PLAIN = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       error;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nib = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.nib = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.nib = 4'(c - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: rtl/pctd_if.sv
interface pctd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface pctd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_error;

  modport source (output valid, output out_byte, output out_last, output out_error,
                  input ready);
  modport sink (input valid, input out_byte, input out_last, input out_error,
                output ready);
endinterface

FILE: rtl/pctd_in_reg.sv
module pctd_in_reg (
  input  logic               clk,
  input  logic               rst,
  pctd_in_if.sink            din,
  input  logic               advance,
  output logic               item_valid,
  output pctd_pkg::in_item_t item
);
  import pctd_pkg::*;

  assign din.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (din.ready) begin
      item_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      item.data <= din.in_byte;
      item.last <= din.in_last;
    end
  end

endmodule

FILE: rtl/pctd_decode.sv
module pctd_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  pctd_pkg::in_item_t  item,
  input  logic                advance,
  output logic                res_valid,
  output pctd_pkg::out_item_t res
);
  import pctd_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;
  logic       digit_bad;
  logic       digit_bad_next;
  logic       emit;
  logic       fire;
  logic       bad;
  hex_t       hv;

  assign hv   = hex_value(item.data);
  assign fire = item_valid && advance;
  assign res_valid = item_valid && emit;

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    digit_bad_next   = digit_bad;
    emit             = 1'b0;
    bad              = 1'b0;
    res              = '0;
    unique case (phase)
      PH_PCT: begin
        phase_next       = PH_DIGIT;
        high_nibble_next = hv.ok ? hv.nib : 4'd0;
        digit_bad_next   = !hv.ok;
        if (item.last) begin
          phase_next       = PH_PLAIN;
          high_nibble_next = 4'd0;
          digit_bad_next   = 1'b0;
          emit             = 1'b1;
          res.last         = 1'b1;
          res.error        = 1'b1;
        end
      end
      PH_DIGIT: begin
        bad              = digit_bad || !hv.ok;
        phase_next       = PH_PLAIN;
        high_nibble_next = 4'd0;
        digit_bad_next   = 1'b0;
        emit             = 1'b1;
        res.data         = bad ? 8'd0 : {high_nibble, hv.nib};
        res.last         = item.last;
        res.error        = bad;
      end
      default: begin
        phase_next = PH_PLAIN;
        if (item.data == CH_PERCENT) begin
          high_nibble_next = 4'd0;
          digit_bad_next   = 1'b0;
          if (item.last) begin
            emit      = 1'b1;
            res.last  = 1'b1;
            res.error = 1'b1;
          end else begin
            phase_next = PH_PCT;
          end
        end else begin
          emit     = 1'b1;
          res.data = (item.data == CH_PLUS) ? CH_SPACE : item.data;
          res.last = item.last;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PLAIN;
      high_nibble <= 4'd0;
      digit_bad   <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      digit_bad   <= digit_bad_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.error |-> res.data == 8'd0)
    else $error("error result carries nonzero data");

  a_last_to_plain: assert property (@(posedge clk) disable iff (rst)
    fire && emit && res.last |=> phase == PH_PLAIN)
    else $error("escape state survives end of string");

  a_pct_silent: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_PLAIN && item.data == CH_PERCENT && !item.last
    |=> phase == PH_PCT && !$past(res_valid))
    else $error("percent did not open an escape");

  a_digit_emits: assert property (@(posedge clk) disable iff (rst)
    item_valid && phase == PH_DIGIT |-> res_valid)
    else $error("second escape digit gave no result");
`endif

endmodule

FILE: rtl/pctd_out_reg.sv
module pctd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  pctd_pkg::out_item_t res,
  output logic                advance,
  pctd_out_if.source          dout
);
  import pctd_pkg::*;

  assign advance = !dout.valid || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      dout.out_byte  <= res.data;
      dout.out_last  <= res.last;
      dout.out_error <= res.error;
    end
  end

endmodule

FILE: rtl/percent_decoder.sv
// URL percent-escape decoder with plus-as-space.
// din carries one encoded byte per transaction (in_byte, in_last marks the
// final byte of a string); dout carries zero or one decoded byte per input
// transaction (out_byte, out_last, out_error). Both channels use valid/ready.
// "%hh" gives one byte, "+" gives a space, all else passes through. A bad hex
// digit or a string that ends inside an escape gives one result with
// out_error set and out_byte zero.
// A byte accepted from din lands in the input register, is decoded and lands
// in the output register, from which its result is offered on dout.
// Throughput: one byte per cycle while dout does not stall, set by the single
// decode step between the input and output registers; escape bytes that give
// no result still pass through that decode step.
// Reset (rst, synchronous) empties both registers and returns the decoder to
// plain text. When dout stalls, the output register holds its transaction and
// din.ready drops as soon as the input register holds a byte.
module percent_decoder (
  input  logic       clk,
  input  logic       rst,
  pctd_in_if.sink    din,
  pctd_out_if.source dout
);
  import pctd_pkg::*;

  logic      advance;
  logic      item_valid;
  in_item_t  item;
  logic      res_valid;
  out_item_t res;

  pctd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  pctd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  pctd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .dout      (dout)
  );

endmodule
